>>> rtl/lnpms_pkg.sv
// shared codes, widths and helper functions for the last-note-priority mode selector
package lnpms_pkg;

    localparam int KEY_W   = 7;
    localparam int VALUE_W = 7;
    localparam int CHAN_W  = 4;
    localparam int ACT_W   = 2;
    localparam int MODE_W  = 2;
    localparam int DIR_W   = 2;
    localparam int SPEED_W = 16;
    localparam int HELD_W  = 8;
    localparam int IN_W    = 24;
    localparam int OUT_W   = 32;

    localparam logic [ACT_W-1:0] ACT_NOTE_ON  = 2'd0;
    localparam logic [ACT_W-1:0] ACT_NOTE_OFF = 2'd1;
    localparam logic [ACT_W-1:0] ACT_CTRL     = 2'd2;
    localparam logic [ACT_W-1:0] ACT_OTHER    = 2'd3;

    localparam logic [MODE_W-1:0] MODE_PASS = 2'd0;
    localparam logic [MODE_W-1:0] MODE_VARI = 2'd1;
    localparam logic [MODE_W-1:0] MODE_MUTE = 2'd2;
    localparam logic [MODE_W-1:0] MODE_STOP = 2'd3;

    localparam logic [DIR_W-1:0] DIR_FWD = 2'b01;
    localparam logic [DIR_W-1:0] DIR_REV = 2'b11;

    localparam logic [KEY_W-1:0] CC_SPEED   = 7'd1;
    localparam logic [KEY_W-1:0] CC_ALL_OFF = 7'd123;

    localparam logic [VALUE_W-1:0] VALUE_MAX = 7'd127;
    localparam logic [SPEED_W-1:0] SPEED_ONE = 16'd32768;

    localparam logic [0:0] ADDR_LISTEN_CHANNEL = 1'b0;
    localparam logic [CHAN_W-1:0] LISTEN_RESET = 4'd15;

    // floor(x * 32768 / 127) = x * 258 + floor(2x / 127)
    function automatic logic [SPEED_W-1:0] speed_of(input logic [VALUE_W-1:0] value);
        logic [VALUE_W-1:0] x;
        logic [VALUE_W:0]   twice;
        logic [1:0]         corr;
        x     = VALUE_MAX - value;
        twice = {x, 1'b0};
        if (twice >= {VALUE_MAX, 1'b0})
            corr = 2'd2;
        else if (twice >= {1'b0, VALUE_MAX})
            corr = 2'd1;
        else
            corr = 2'd0;
        return ({1'b0, x, 8'd0}) + ({8'd0, x, 1'b0}) + {14'd0, corr};
    endfunction

    function automatic logic [MODE_W-1:0] mode_of(input logic [KEY_W-1:0] key);
        logic [MODE_W-1:0] m;
        unique case (key[1:0])
            2'd0, 2'd1: m = MODE_VARI;
            2'd2:       m = MODE_MUTE;
            default:    m = MODE_STOP;
        endcase
        return m;
    endfunction

endpackage

>>> rtl/last_note_priority_mode_selector.sv
// Last-note-priority mode selector: takes parsed MIDI items on one channel and keeps a
// stack of held keys in a memory with one read and one write port. A note item walks the
// stack one entry per cycle through one shared compare unit and compacts it in place; a
// release that leaves keys held then reads the new top of the stack. When the stack is
// full, a press adds a second walk to drop the oldest key. Control change and ignored
// items do not walk the stack. The block takes no new item while one is in work, and an
// item cannot finish while the previous result still waits unaccepted in the output
// register.
module last_note_priority_mode_selector #(
    parameter int NOTE_COUNT = 128
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     s_tvalid,
    output logic                     s_tready,
    // action[1:0], channel[5:2], data_first[12:6], data_second[19:13], zero pad
    input  logic [lnpms_pkg::IN_W-1:0]  s_tdata,
    output logic                     m_tvalid,
    input  logic                     m_tready,
    // play_mode[1:0], play_direction[3:2], play_speed[19:4], held_count[27:20], zero pad
    output logic [lnpms_pkg::OUT_W-1:0] m_tdata,
    input  logic                     psel,
    input  logic                     penable,
    input  logic                     pwrite,
    input  logic [0:0]               paddr,
    input  logic [31:0]              pwdata,
    output logic [31:0]              prdata,
    output logic                     pready
);

    localparam int IW = $clog2(NOTE_COUNT);
    localparam int CW = $clog2(NOTE_COUNT + 1);

    localparam logic [2:0] ST_IDLE     = 3'd0;
    localparam logic [2:0] ST_DISPATCH = 3'd1;
    localparam logic [2:0] ST_SCAN     = 3'd2;
    localparam logic [2:0] ST_PUSH     = 3'd3;
    localparam logic [2:0] ST_TOP      = 3'd4;
    localparam logic [2:0] ST_TOP_WAIT = 3'd5;
    localparam logic [2:0] ST_DONE     = 3'd6;

    logic [2:0]                       state_reg, state_next;
    logic [CW-1:0]                    count_reg, count_next;
    logic [CW-1:0]                    rd_reg, rd_next;
    logic [CW-1:0]                    wr_reg, wr_next;
    logic [IW-1:0]                    didx_reg, didx_next;
    logic                             pend_reg, pend_next;
    logic                             drop_first_reg, drop_first_next;
    logic                             press_reg, press_next;
    logic [lnpms_pkg::KEY_W-1:0]      key_reg;
    logic [lnpms_pkg::MODE_W-1:0]     mode_reg, mode_next;
    logic [lnpms_pkg::DIR_W-1:0]      dir_reg, dir_next;
    logic [lnpms_pkg::SPEED_W-1:0]    speed_reg, speed_next;
    logic [lnpms_pkg::CHAN_W-1:0]     listen_reg;
    logic                             out_valid_reg, out_valid_next;
    logic [lnpms_pkg::OUT_W-1:0]      out_data_reg;
    logic                             out_load;

    logic [lnpms_pkg::ACT_W-1:0]      in_action;
    logic [lnpms_pkg::CHAN_W-1:0]     in_channel;
    logic [lnpms_pkg::KEY_W-1:0]      in_first;
    logic [lnpms_pkg::VALUE_W-1:0]    in_second;
    logic [lnpms_pkg::ACT_W-1:0]      act_reg;
    logic [lnpms_pkg::CHAN_W-1:0]     chan_reg;
    logic [lnpms_pkg::VALUE_W-1:0]    second_reg;

    logic [lnpms_pkg::KEY_W-1:0]      mem [NOTE_COUNT];
    logic [lnpms_pkg::KEY_W-1:0]      rdata_reg;
    logic                             we;
    logic [IW-1:0]                    waddr;
    logic [IW-1:0]                    raddr;
    logic [lnpms_pkg::KEY_W-1:0]      wdata;
    logic [CW-1:0]                    top_idx;
    logic                             drop;
    logic                             cfg_write;
    logic                             accept;

    assign in_action  = s_tdata[1:0];
    assign in_channel = s_tdata[5:2];
    assign in_first   = s_tdata[12:6];
    assign in_second  = s_tdata[19:13];

    assign s_tready  = (state_reg == ST_IDLE);
    assign accept    = s_tvalid && s_tready;
    assign m_tvalid  = out_valid_reg;
    assign m_tdata   = out_data_reg;
    assign pready    = 1'b1;
    assign prdata    = 32'(listen_reg);
    assign cfg_write = psel && penable && pwrite && pready;

    assign top_idx = count_reg - CW'(1);
    assign drop    = drop_first_reg ? (didx_reg == '0) : (rdata_reg == key_reg);

    always_comb
    begin
        state_next      = state_reg;
        count_next      = count_reg;
        rd_next         = rd_reg;
        wr_next         = wr_reg;
        didx_next       = didx_reg;
        pend_next       = pend_reg;
        drop_first_next = drop_first_reg;
        press_next      = press_reg;
        mode_next       = mode_reg;
        dir_next        = dir_reg;
        speed_next      = speed_reg;
        out_valid_next  = out_valid_reg;
        out_load        = 1'b0;
        we              = 1'b0;
        waddr           = wr_reg[IW-1:0];
        wdata           = rdata_reg;
        raddr           = rd_reg[IW-1:0];

        if (out_valid_reg && m_tready)
            out_valid_next = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                    state_next = ST_DISPATCH;
            end
            ST_DISPATCH:
            begin
                state_next      = ST_DONE;
                rd_next         = '0;
                wr_next         = '0;
                pend_next       = 1'b0;
                drop_first_next = 1'b0;
                if (chan_reg == listen_reg)
                begin
                    unique case (act_reg)
                        lnpms_pkg::ACT_NOTE_ON:
                        begin
                            press_next = (second_reg != '0);
                            state_next = ST_SCAN;
                        end
                        lnpms_pkg::ACT_NOTE_OFF:
                        begin
                            press_next = 1'b0;
                            state_next = ST_SCAN;
                        end
                        lnpms_pkg::ACT_CTRL:
                        begin
                            if (key_reg == lnpms_pkg::CC_SPEED)
                                speed_next = lnpms_pkg::speed_of(second_reg);
                            else if (key_reg == lnpms_pkg::CC_ALL_OFF)
                            begin
                                count_next = '0;
                                mode_next  = lnpms_pkg::MODE_PASS;
                            end
                        end
                        default:
                        begin
                            state_next = ST_DONE;
                        end
                    endcase
                end
            end
            ST_SCAN:
            begin
                // compact the stack in place, one entry per cycle
                if (pend_reg && !drop)
                begin
                    we      = 1'b1;
                    wr_next = wr_reg + CW'(1);
                end
                if (rd_reg < count_reg)
                begin
                    rd_next   = rd_reg + CW'(1);
                    didx_next = rd_reg[IW-1:0];
                    pend_next = 1'b1;
                end
                else
                begin
                    pend_next = 1'b0;
                    if (!pend_reg)
                    begin
                        count_next = wr_reg;
                        if (drop_first_reg)
                        begin
                            drop_first_next = 1'b0;
                            state_next      = ST_PUSH;
                        end
                        else if (press_reg)
                        begin
                            if (wr_reg == CW'(NOTE_COUNT))
                            begin
                                // full: drop the oldest key
                                rd_next         = '0;
                                wr_next         = '0;
                                drop_first_next = 1'b1;
                            end
                            else
                                state_next = ST_PUSH;
                        end
                        else if (wr_reg != '0)
                            state_next = ST_TOP;
                        else
                        begin
                            mode_next  = lnpms_pkg::MODE_PASS;
                            state_next = ST_DONE;
                        end
                    end
                end
            end
            ST_PUSH:
            begin
                we         = 1'b1;
                waddr      = count_reg[IW-1:0];
                wdata      = key_reg;
                count_next = count_reg + CW'(1);
                mode_next  = lnpms_pkg::mode_of(key_reg);
                if (mode_next == lnpms_pkg::MODE_VARI)
                    dir_next = key_reg[0] ? lnpms_pkg::DIR_REV : lnpms_pkg::DIR_FWD;
                state_next = ST_DONE;
            end
            ST_TOP:
            begin
                raddr      = top_idx[IW-1:0];
                state_next = ST_TOP_WAIT;
            end
            ST_TOP_WAIT:
            begin
                mode_next = lnpms_pkg::mode_of(rdata_reg);
                if (mode_next == lnpms_pkg::MODE_VARI)
                    dir_next = rdata_reg[0] ? lnpms_pkg::DIR_REV : lnpms_pkg::DIR_FWD;
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (!out_valid_reg || m_tready)
                begin
                    out_load       = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            count_reg      <= '0;
            rd_reg         <= '0;
            wr_reg         <= '0;
            didx_reg       <= '0;
            pend_reg       <= 1'b0;
            drop_first_reg <= 1'b0;
            press_reg      <= 1'b0;
            mode_reg       <= lnpms_pkg::MODE_PASS;
            dir_reg        <= lnpms_pkg::DIR_FWD;
            speed_reg      <= lnpms_pkg::SPEED_ONE;
            listen_reg     <= lnpms_pkg::LISTEN_RESET;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            count_reg      <= count_next;
            rd_reg         <= rd_next;
            wr_reg         <= wr_next;
            didx_reg       <= didx_next;
            pend_reg       <= pend_next;
            drop_first_reg <= drop_first_next;
            press_reg      <= press_next;
            mode_reg       <= mode_next;
            dir_reg        <= dir_next;
            speed_reg      <= speed_next;
            out_valid_reg  <= out_valid_next;
            if (cfg_write && paddr == lnpms_pkg::ADDR_LISTEN_CHANNEL)
                listen_reg <= pwdata[lnpms_pkg::CHAN_W-1:0];
        end
    end

    // item payload and result register
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            act_reg    <= in_action;
            chan_reg   <= in_channel;
            key_reg    <= in_first;
            second_reg <= in_second;
        end
        if (out_load)
            out_data_reg <= {4'd0, lnpms_pkg::HELD_W'(count_reg), speed_reg, dir_reg, mode_reg};
    end

    // key stack memory
    always_ff @(posedge clk)
    begin
        if (we)
            mem[waddr] <= wdata;
        rdata_reg <= mem[raddr];
    end

    assert property (@(posedge clk) disable iff (!rst_n) count_reg <= CW'(NOTE_COUNT))
        else $error("stack count above depth");

    assert property (@(posedge clk) disable iff (!rst_n) (state_reg == ST_SCAN) |-> wr_reg <= rd_reg)
        else $error("compaction write ahead of read");

    assert property (@(posedge clk) disable iff (!rst_n) accept |=> !s_tready)
        else $error("ready right after accept");

    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[3:2] == lnpms_pkg::DIR_FWD || m_tdata[3:2] == lnpms_pkg::DIR_REV))
        else $error("bad direction code");

    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_PUSH) |-> count_reg < CW'(NOTE_COUNT))
        else $error("push onto full stack");

endmodule
